@@ design/servo_velocity_loop_core_macros.svh @@
// Assertion macros shared by the servo velocity loop design files.
`ifndef SERVO_VELOCITY_LOOP_CORE_MACROS_SVH
`define SERVO_VELOCITY_LOOP_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SVL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SVL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/svl_pkg.sv @@
// Types, constants, saturation helpers and microprogram of the servo velocity loop.
`timescale 1ns / 1ps
package svl_pkg;

    localparam int DW     = 32;
    localparam int MW     = 33;
    localparam int PW     = 66;
    localparam int QS     = 16;
    localparam int AW     = 16;
    localparam int IN_W   = 96;
    localparam int OUT_W  = 64;
    localparam int CIDX_W = 3;
    localparam int STEP_W = 5;

    localparam logic [DW-1:0] SAMPLE_RATE_RST = 32'd65536000;
    localparam logic signed [DW-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DW-1:0] S32_MIN = 32'sh8000_0000;

    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [2:0] {
        MA_T,
        MA_GVFF,
        MA_GVP,
        MA_GACC,
        MA_ALPHA_C,
        MA_ALPHA
    } ma_sel_t;

    typedef enum logic [2:0] {
        MB_T,
        MB_SR,
        MB_SMOOTH,
        MB_VFF,
        MB_AFF
    } mb_sel_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_DIFF,
        OP_LOAD_ACC,
        OP_FILT,
        OP_SCALE_T,
        OP_ERR,
        OP_CLAMP,
        OP_SCALE_U,
        OP_ADD,
        OP_FINISH
    } alu_op_t;

    typedef enum logic [1:0] {
        JC_NONE,
        JC_NO_ITEM,
        JC_OUT_BUSY
    } jmp_cond_t;

    typedef enum logic [CIDX_W-1:0] {
        CFG_GAIN_VEL_P  = 3'd0,
        CFG_GAIN_VEL_FF = 3'd1,
        CFG_GAIN_ACC_FF = 3'd2,
        CFG_FILTER_ALPHA = 3'd3,
        CFG_SAMPLE_RATE = 3'd4,
        CFG_OUT_MAX     = 3'd5,
        CFG_OUT_MIN     = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic      mul_en;
        ma_sel_t   ma;
        mb_sel_t   mb;
        alu_op_t   op;
        jmp_cond_t jc;
        step_t     target;
        logic      last;
    } ctrl_t;

    typedef struct packed {
        logic signed [DW-1:0] gain_vel_p;
        logic signed [DW-1:0] gain_vel_ff;
        logic signed [DW-1:0] gain_acc_ff;
        logic [AW-1:0]        filter_alpha;
        logic [DW-1:0]        sample_rate;
        logic signed [DW-1:0] out_max;
        logic signed [DW-1:0] out_min;
    } cfg_t;

    typedef struct packed {
        logic signed [DW-1:0] drive;
        logic                 saturated;
        logic signed [DW-1:0] limit_excess;
    } result_t;

    // saturate a 33-bit sum or difference to 32 bits
    function automatic logic signed [DW-1:0] sat33(input logic [MW-1:0] v);
        logic signed [DW-1:0] r;
        if (v[MW-1] != v[MW-2]) begin
            r = v[MW-1] ? S32_MIN : S32_MAX;
        end else begin
            r = $signed(v[DW-1:0]);
        end
        return r;
    endfunction

    // floor shift of a Q32.32 product back to Q16.16, then saturate
    function automatic logic signed [DW-1:0] satshift(input logic [PW-1:0] p);
        logic [PW-QS-1:0] s;
        logic signed [DW-1:0] r;
        s = p[PW-1:QS];
        if (s[PW-QS-1:DW-1] != {(PW-QS-DW+1){s[PW-QS-1]}}) begin
            r = s[PW-QS-1] ? S32_MIN : S32_MAX;
        end else begin
            r = $signed(s[DW-1:0]);
        end
        return r;
    endfunction

    function automatic ctrl_t mk(input logic mul_en, input ma_sel_t ma, input mb_sel_t mb,
                                 input alu_op_t op, input jmp_cond_t jc, input step_t target,
                                 input logic last);
        ctrl_t c;
        c.mul_en = mul_en;
        c.ma     = ma;
        c.mb     = mb;
        c.op     = op;
        c.jc     = jc;
        c.target = target;
        c.last   = last;
        return c;
    endfunction

    // control store: one word per step
    function automatic ctrl_t ucode(input step_t s);
        ctrl_t c;
        case (s)
            5'd0:    c = mk(1'b0, MA_T, MB_T, OP_NOP, JC_NO_ITEM, 5'd0, 1'b0);
            5'd1:    c = mk(1'b0, MA_T, MB_T, OP_DIFF, JC_NONE, 5'd0, 1'b0);
            5'd2:    c = mk(1'b1, MA_T, MB_SR, OP_NOP, JC_NONE, 5'd0, 1'b0);
            5'd3:    c = mk(1'b0, MA_T, MB_T, OP_SCALE_T, JC_NONE, 5'd0, 1'b0);
            5'd4:    c = mk(1'b1, MA_ALPHA_C, MB_T, OP_NOP, JC_NONE, 5'd0, 1'b0);
            5'd5:    c = mk(1'b1, MA_ALPHA, MB_SMOOTH, OP_LOAD_ACC, JC_NONE, 5'd0, 1'b0);
            5'd6:    c = mk(1'b0, MA_T, MB_T, OP_FILT, JC_NONE, 5'd0, 1'b0);
            5'd7:    c = mk(1'b1, MA_GVFF, MB_VFF, OP_NOP, JC_NONE, 5'd0, 1'b0);
            5'd8:    c = mk(1'b0, MA_T, MB_T, OP_SCALE_T, JC_NONE, 5'd0, 1'b0);
            5'd9:    c = mk(1'b0, MA_T, MB_T, OP_ERR, JC_NONE, 5'd0, 1'b0);
            5'd10:   c = mk(1'b1, MA_GVP, MB_T, OP_NOP, JC_NONE, 5'd0, 1'b0);
            5'd11:   c = mk(1'b0, MA_T, MB_T, OP_SCALE_T, JC_NONE, 5'd0, 1'b0);
            5'd12:   c = mk(1'b0, MA_T, MB_T, OP_CLAMP, JC_NONE, 5'd0, 1'b0);
            5'd13:   c = mk(1'b1, MA_GACC, MB_AFF, OP_NOP, JC_NONE, 5'd0, 1'b0);
            5'd14:   c = mk(1'b0, MA_T, MB_T, OP_SCALE_U, JC_NONE, 5'd0, 1'b0);
            5'd15:   c = mk(1'b0, MA_T, MB_T, OP_ADD, JC_NONE, 5'd0, 1'b0);
            5'd16:   c = mk(1'b0, MA_T, MB_T, OP_FINISH, JC_OUT_BUSY, 5'd16, 1'b1);
            default: c = mk(1'b0, MA_T, MB_T, OP_NOP, JC_NONE, 5'd0, 1'b1);
        endcase
        return c;
    endfunction

endpackage

@@ design/svl_sequencer.sv @@
// Step counter with conditional jumps over the velocity loop control store.
`timescale 1ns / 1ps
module svl_sequencer (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             item_accept,
    input  logic             out_busy,
    output svl_pkg::ctrl_t   ctrl
);

    svl_pkg::step_t step_reg;
    svl_pkg::step_t step_next;
    logic           jump;

    assign ctrl = svl_pkg::ucode(step_reg);

    always_comb begin
        case (ctrl.jc)
            svl_pkg::JC_NO_ITEM:  jump = !item_accept;
            svl_pkg::JC_OUT_BUSY: jump = out_busy;
            default:              jump = 1'b0;
        endcase
    end

    always_comb begin
        if (jump) begin
            step_next = ctrl.target;
        end else if (ctrl.last) begin
            step_next = '0;
        end else begin
            step_next = step_reg + svl_pkg::step_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

@@ design/svl_datapath.sv @@
// Velocity loop datapath: shared multiplier, work registers, saturation and clamp.
`timescale 1ns / 1ps
module svl_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  svl_pkg::ctrl_t                ctrl,
    input  svl_pkg::cfg_t                 cfg,
    input  logic                          item_accept,
    input  logic [svl_pkg::IN_W-1:0]      item_data,
    output svl_pkg::result_t              result
);

    logic signed [svl_pkg::DW-1:0] pos_reg, vff_reg, aff_reg;
    logic signed [svl_pkg::DW-1:0] pos_next, vff_next, aff_next;
    logic signed [svl_pkg::DW-1:0] prev_reg, prev_next;
    logic signed [svl_pkg::DW-1:0] smooth_reg, smooth_next;
    logic                          first_reg, first_next;
    logic signed [svl_pkg::DW-1:0] t_reg, t_next;
    logic signed [svl_pkg::DW-1:0] u_reg, u_next;
    logic signed [svl_pkg::DW-1:0] excess_reg, excess_next;
    logic [svl_pkg::PW-1:0]        acc_reg, acc_next;
    logic [svl_pkg::PW-1:0]        prod_reg, prod_next;

    logic signed [svl_pkg::MW-1:0] ma, mb;
    logic                          lim_eq, above, below;
    logic signed [svl_pkg::DW-1:0] clamp_val, clamp_exc;
    logic                          clamp_hit;

    always_comb begin
        case (ctrl.ma)
            svl_pkg::MA_T:       ma = {t_reg[31], t_reg};
            svl_pkg::MA_GVFF:    ma = {cfg.gain_vel_ff[31], cfg.gain_vel_ff};
            svl_pkg::MA_GVP:     ma = {cfg.gain_vel_p[31], cfg.gain_vel_p};
            svl_pkg::MA_GACC:    ma = {cfg.gain_acc_ff[31], cfg.gain_acc_ff};
            svl_pkg::MA_ALPHA_C: ma = {16'b0, 17'h1_0000 - {1'b0, cfg.filter_alpha}};
            svl_pkg::MA_ALPHA:   ma = {17'b0, cfg.filter_alpha};
            default:             ma = '0;
        endcase
    end

    always_comb begin
        case (ctrl.mb)
            svl_pkg::MB_T:      mb = {t_reg[31], t_reg};
            svl_pkg::MB_SR:     mb = {1'b0, cfg.sample_rate};
            svl_pkg::MB_SMOOTH: mb = {smooth_reg[31], smooth_reg};
            svl_pkg::MB_VFF:    mb = {vff_reg[31], vff_reg};
            svl_pkg::MB_AFF:    mb = {aff_reg[31], aff_reg};
            default:            mb = '0;
        endcase
    end

    // limit check on the work register; crossed limits test the upper one first
    always_comb begin
        lim_eq    = cfg.out_max == cfg.out_min;
        above     = $signed(t_reg) > $signed(cfg.out_max);
        below     = $signed(t_reg) < $signed(cfg.out_min);
        clamp_val = t_reg;
        clamp_exc = '0;
        clamp_hit = 1'b0;
        if (!lim_eq && above) begin
            clamp_val = cfg.out_max;
            clamp_exc = svl_pkg::sat33({cfg.out_max[31], cfg.out_max} - {t_reg[31], t_reg});
            clamp_hit = 1'b1;
        end else if (!lim_eq && below) begin
            clamp_val = cfg.out_min;
            clamp_exc = svl_pkg::sat33({cfg.out_min[31], cfg.out_min} - {t_reg[31], t_reg});
            clamp_hit = 1'b1;
        end
    end

    always_comb begin
        pos_next    = pos_reg;
        vff_next    = vff_reg;
        aff_next    = aff_reg;
        prev_next   = prev_reg;
        smooth_next = smooth_reg;
        first_next  = first_reg;
        t_next      = t_reg;
        u_next      = u_reg;
        excess_next = excess_reg;
        acc_next    = acc_reg;
        prod_next   = ctrl.mul_en ? svl_pkg::PW'(ma * mb) : prod_reg;

        if (item_accept) begin
            pos_next = $signed(item_data[31:0]);
            vff_next = $signed(item_data[63:32]);
            aff_next = $signed(item_data[95:64]);
            if (first_reg) begin
                prev_next   = $signed(item_data[31:0]);
                smooth_next = '0;
                first_next  = 1'b0;
            end
        end

        case (ctrl.op)
            svl_pkg::OP_DIFF: begin
                t_next    = svl_pkg::sat33({pos_reg[31], pos_reg} - {prev_reg[31], prev_reg});
                prev_next = pos_reg;
            end
            svl_pkg::OP_LOAD_ACC: acc_next = prod_reg;
            svl_pkg::OP_FILT:     smooth_next = svl_pkg::satshift(acc_reg + prod_reg);
            svl_pkg::OP_SCALE_T:  t_next = svl_pkg::satshift(prod_reg);
            svl_pkg::OP_ERR: begin
                t_next = svl_pkg::sat33({t_reg[31], t_reg} - {smooth_reg[31], smooth_reg});
            end
            svl_pkg::OP_CLAMP: begin
                t_next      = clamp_val;
                excess_next = clamp_exc;
            end
            svl_pkg::OP_SCALE_U:  u_next = svl_pkg::satshift(prod_reg);
            svl_pkg::OP_ADD:      t_next = svl_pkg::sat33({t_reg[31], t_reg} + {u_reg[31], u_reg});
            default: ;
        endcase
    end

    assign result.drive        = clamp_val;
    assign result.saturated    = clamp_hit;
    assign result.limit_excess = excess_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg   <= '0;
            smooth_reg <= '0;
            first_reg  <= 1'b1;
        end else begin
            prev_reg   <= prev_next;
            smooth_reg <= smooth_next;
            first_reg  <= first_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg    <= pos_next;
        vff_reg    <= vff_next;
        aff_reg    <= aff_next;
        t_reg      <= t_next;
        u_reg      <= u_next;
        excess_reg <= excess_next;
        acc_reg    <= acc_next;
        prod_reg   <= prod_next;
    end

endmodule

@@ design/servo_velocity_loop_core.sv @@
// Servo velocity loop top level: stream ports, register file, output stage.
//
//   channel   direction  handshake             contents
//   s_*       in         s_tvalid / s_tready   pos_measured, vel_ff, acc_ff
//   m_*       out        m_tvalid / m_tready   drive, limit_excess; saturated in tuser
//   cfg_*     in         cfg_valid / cfg_ready register index, write data
//
// Step 0 takes the item; steps 1 to 16 compute it on one shared 33x33 multiplier.
// m_tvalid is registered from the last step; a new item is taken only after that step.
// aresetn is synchronous; it clears the loop state and restores register defaults.
// A finished result waits in the output register; the last step stalls only if
// the previous result is still not taken. Configuration writes are always taken.
`timescale 1ns / 1ps
`include "servo_velocity_loop_core_macros.svh"
module servo_velocity_loop_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // pos_measured, vel_ff, acc_ff
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // drive, limit_excess
    output logic [0:0]  m_tuser,   // saturated
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    svl_pkg::cfg_t    cfg_reg, cfg_next;
    svl_pkg::ctrl_t   ctrl;
    svl_pkg::result_t result;
    svl_pkg::result_t out_reg, out_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic             item_accept, out_busy, out_fire;

    assign cfg_ready   = 1'b1;
    assign s_tready    = ctrl.jc == svl_pkg::JC_NO_ITEM;
    assign item_accept = s_tvalid && s_tready;
    assign out_busy    = m_tvalid_reg && !m_tready;
    assign out_fire    = (ctrl.op == svl_pkg::OP_FINISH) && !out_busy;

    svl_sequencer u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_accept (item_accept),
        .out_busy    (out_busy),
        .ctrl        (ctrl)
    );

    svl_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .cfg         (cfg_reg),
        .item_accept (item_accept),
        .item_data   (s_tdata),
        .result      (result)
    );

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            case (svl_pkg::cfg_idx_t'(cfg_index))
                svl_pkg::CFG_GAIN_VEL_P:   cfg_next.gain_vel_p   = $signed(cfg_data);
                svl_pkg::CFG_GAIN_VEL_FF:  cfg_next.gain_vel_ff  = $signed(cfg_data);
                svl_pkg::CFG_GAIN_ACC_FF:  cfg_next.gain_acc_ff  = $signed(cfg_data);
                svl_pkg::CFG_FILTER_ALPHA: cfg_next.filter_alpha = cfg_data[15:0];
                svl_pkg::CFG_SAMPLE_RATE:  cfg_next.sample_rate  = cfg_data;
                svl_pkg::CFG_OUT_MAX:      cfg_next.out_max      = $signed(cfg_data);
                svl_pkg::CFG_OUT_MIN:      cfg_next.out_min      = $signed(cfg_data);
                default: ;
            endcase
        end
    end

    always_comb begin
        out_next      = out_fire ? result : out_reg;
        m_tvalid_next = out_fire ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_vel_p   <= '0;
            cfg_reg.gain_vel_ff  <= '0;
            cfg_reg.gain_acc_ff  <= '0;
            cfg_reg.filter_alpha <= '0;
            cfg_reg.sample_rate  <= svl_pkg::SAMPLE_RATE_RST;
            cfg_reg.out_max      <= '0;
            cfg_reg.out_min      <= '0;
            m_tvalid_reg         <= 1'b0;
        end else begin
            cfg_reg      <= cfg_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_reg.limit_excess, out_reg.drive};
    assign m_tuser  = out_reg.saturated;

    `SVL_ASSERT_NEXT(a_fire_shows_result, out_fire, m_tvalid, "finished item not presented")
    `SVL_ASSERT_SAME(a_no_overwrite, m_tvalid && !m_tready, !out_fire, "pending result overwritten")
    `SVL_ASSERT_NEXT(a_accept_starts_work, item_accept, !s_tready, "sequencer stayed idle")

endmodule
